### hdl/tkli_pkg.sv
`default_nettype none
package tkli_pkg;

    // Table geometry
    localparam int NODES     = 256;
    localparam int CHILDREN  = 63;
    localparam int VALUE_IDS = 256;

    localparam int NODE_W  = $clog2(NODES);
    localparam int COUNT_W = $clog2(NODES + 1);
    localparam int SLOT_W  = $clog2(CHILDREN + 1);
    localparam int ADDR_W  = $clog2(NODES * CHILDREN);
    localparam int VAL_W   = 8;
    localparam int CH_W    = 8;

    localparam logic [SLOT_W-1:0]  NO_SLOT   = SLOT_W'(CHILDREN);
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(CHILDREN - 1);
    localparam logic [COUNT_W-1:0] NODE_LIMIT = COUNT_W'(NODES);
    localparam logic [VAL_W:0]     VID_LIMIT  = (VAL_W + 1)'(VALUE_IDS);

    // Command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Characters with special meaning
    localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CH_W-1:0] CH_EQ   = 8'h3D;
    localparam logic [CH_W-1:0] CH_DASH = 8'h2D;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INVALID   = 3'd2,
        ST_FULL      = 3'd3,
        ST_DUP       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_EXEC
    } fsm_state_t;

    typedef struct packed {
        logic            cmd;
        logic [CH_W-1:0] ch;
        logic [VAL_W-1:0] value_id;
    } s_item_t;

    typedef struct packed {
        status_t          status;
        logic [VAL_W-1:0] found_value;
        logic             value_follows;
        logic [7:0]       end_node;
    } m_item_t;

    // Requests to the node store
    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_node;
        logic [SLOT_W-1:0] rd_slot;
        logic              cw_en;
        logic [NODE_W-1:0] cw_node;
        logic [SLOT_W-1:0] cw_slot;
        logic [NODE_W-1:0] cw_data;
        logic              vw_en;
        logic [NODE_W-1:0] vw_node;
        logic [VAL_W-1:0]  vw_data;
    } tkli_mem_req_t;

    // Map a key character to its child slot, NO_SLOT if not allowed
    function automatic logic [SLOT_W-1:0] slot_of(input logic [CH_W-1:0] c);
        logic [SLOT_W-1:0] s;
        s = NO_SLOT;
        if (c >= 8'h61 && c <= 8'h7A) begin
            s = SLOT_W'(c - 8'h61);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            s = SLOT_W'(c - 8'h41 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = SLOT_W'(c - 8'h30 + 8'd52);
        end else if (c == CH_DASH) begin
            s = LAST_SLOT;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

### hdl/tkli_store.sv
`default_nettype none
module tkli_store
    import tkli_pkg::*;
(
    input  wire logic              aclk,
    input  wire tkli_mem_req_t     req,
    output logic [NODE_W-1:0]      child_q,
    output logic [VAL_W-1:0]       value_q
);

    logic [NODE_W-1:0] child_mem [0:NODES*CHILDREN-1];
    logic [VAL_W-1:0]  value_mem [0:NODES-1];

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    // Flatten node and slot into a row-major address
    assign rd_addr = ADDR_W'(req.rd_node) * ADDR_W'(CHILDREN) + ADDR_W'(req.rd_slot);
    assign wr_addr = ADDR_W'(req.cw_node) * ADDR_W'(CHILDREN) + ADDR_W'(req.cw_slot);

    // Child table: one read, one write port
    always_ff @(posedge aclk) begin
        if (req.cw_en) begin
            child_mem[wr_addr] <= req.cw_data;
        end
        if (req.rd_en) begin
            child_q <= child_mem[rd_addr];
        end
    end

    // Value table: one read, one write port
    always_ff @(posedge aclk) begin
        if (req.vw_en) begin
            value_mem[req.vw_node] <= req.vw_data;
        end
        if (req.rd_en) begin
            value_q <= value_mem[req.rd_node];
        end
    end

endmodule
`default_nettype wire

### hdl/trie_keyword_lookup_insert_top.sv
`default_nettype none
// Character trie keyword store. Keys arrive one character per item on the
// s_ channel (valid/ready), each tagged lookup or insert; a NUL ends a key.
// Lookups end at NUL or '=' and report the stored value id; inserts store
// their value id at NUL. At most one result per item leaves on the m_
// channel (valid/ready) from an output register.
// Each character is handled in two steps: a read of the current node's
// child entry for its slot and value from the node store, then a decide
// and update step; the next character walks from the node that read
// returns. Allocating a new node adds a sweep that clears its child row.
// An item's result is registered when its decide step commits. After
// reset the root row is cleared with s_ready low.
// When the receiver stalls, the result waits in the output register and the
// next item is still taken; an item that must produce a result while the
// register is full holds until the register frees up.
module trie_keyword_lookup_insert_top
    import tkli_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire s_item_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output m_item_t      m_data
);

    fsm_state_t state_reg, state_next;

    s_item_t            item_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [COUNT_W-1:0] count_reg;
    logic               skip_reg, skip_next;
    logic [NODE_W-1:0]  clr_row_reg;
    logic [SLOT_W-1:0]  clr_idx_reg;
    logic               m_valid_reg;
    m_item_t            m_item_reg;

    tkli_mem_req_t      mem_req;
    logic [NODE_W-1:0]  child_q;
    logic [VAL_W-1:0]   value_q;

    logic [SLOT_W-1:0]  in_slot;
    logic               out_free;
    logic               emit;
    logic               alloc;
    logic               store_val;
    logic               go;
    m_item_t            res;

    tkli_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .child_q (child_q),
        .value_q (value_q)
    );

    assign in_slot  = slot_of(s_data.ch);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_item_reg;

    // Decide the outcome of the character under work
    always_comb begin
        emit      = 1'b0;
        alloc     = 1'b0;
        store_val = 1'b0;
        node_next = node_reg;
        skip_next = skip_reg;
        res.status        = ST_OK;
        res.found_value   = '0;
        res.value_follows = 1'b0;
        res.end_node      = 8'(node_reg);
        if (skip_reg) begin
            if (item_reg.ch == CH_NUL) begin
                skip_next = 1'b0;
                node_next = '0;
            end
        end else if (item_reg.cmd == CMD_LOOKUP) begin
            if (item_reg.ch == CH_NUL || item_reg.ch == CH_EQ) begin
                emit = 1'b1;
                res.status        = (value_q != '0) ? ST_OK : ST_NOT_FOUND;
                res.found_value   = value_q;
                res.value_follows = (item_reg.ch == CH_EQ);
            end else if (slot_reg == NO_SLOT || child_q == '0) begin
                emit = 1'b1;
                res.status = ST_NOT_FOUND;
            end else begin
                node_next = child_q;
            end
        end else begin
            if (item_reg.value_id == '0 || {1'b0, item_reg.value_id} >= VID_LIMIT) begin
                emit = 1'b1;
                res.status = ST_INVALID;
            end else if (item_reg.ch == CH_NUL) begin
                emit = 1'b1;
                if (value_q != '0) begin
                    res.status      = ST_DUP;
                    res.found_value = value_q;
                end else begin
                    store_val       = 1'b1;
                    res.found_value = item_reg.value_id;
                end
            end else if (slot_reg == NO_SLOT) begin
                emit = 1'b1;
                res.status = ST_INVALID;
            end else if (child_q == '0) begin
                if (count_reg >= NODE_LIMIT) begin
                    emit = 1'b1;
                    res.status = ST_FULL;
                end else begin
                    alloc     = 1'b1;
                    node_next = count_reg[NODE_W-1:0];
                end
            end else begin
                node_next = child_q;
            end
        end
        // A result returns the walk to the root
        if (emit) begin
            node_next = '0;
            skip_next = (item_reg.ch != CH_NUL);
        end
    end

    assign go = !emit || out_free;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_CLEAR: begin
                if (clr_idx_reg == LAST_SLOT) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                if (s_valid) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (go) begin
                    state_next = alloc ? FSM_CLEAR : FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // Outputs: handshake and store requests
    always_comb begin
        s_ready = 1'b0;
        mem_req = '0;
        case (state_reg)
            FSM_CLEAR: begin
                mem_req.cw_en   = 1'b1;
                mem_req.cw_node = clr_row_reg;
                mem_req.cw_slot = clr_idx_reg;
                mem_req.vw_en   = 1'b1;
                mem_req.vw_node = clr_row_reg;
            end
            FSM_IDLE: begin
                s_ready         = 1'b1;
                mem_req.rd_en   = s_valid;
                mem_req.rd_node = node_reg;
                mem_req.rd_slot = (in_slot == NO_SLOT) ? '0 : in_slot;
            end
            FSM_EXEC: begin
                mem_req.cw_en   = go && alloc;
                mem_req.cw_node = node_reg;
                mem_req.cw_slot = slot_reg;
                mem_req.cw_data = count_reg[NODE_W-1:0];
                mem_req.vw_en   = go && store_val;
                mem_req.vw_node = node_reg;
                mem_req.vw_data = item_reg.value_id;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_CLEAR;
            node_reg    <= '0;
            count_reg   <= COUNT_W'(1);
            skip_reg    <= 1'b0;
            clr_row_reg <= '0;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Advance the row sweep
            if (state_reg == FSM_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            // Commit the character's effects
            if (state_reg == FSM_EXEC && go) begin
                node_reg <= node_next;
                skip_reg <= skip_next;
                if (alloc) begin
                    count_reg   <= count_reg + 1'b1;
                    clr_row_reg <= count_reg[NODE_W-1:0];
                    clr_idx_reg <= '0;
                end
            end
            // Load or drop the output item
            if (state_reg == FSM_EXEC && go && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == FSM_IDLE && s_valid) begin
            item_reg <= s_data;
            slot_reg <= in_slot;
        end
        if (state_reg == FSM_EXEC && go && emit) begin
            m_item_reg <= res;
        end
    end

endmodule
`default_nettype wire
